[rtl/core/rru_pkg.sv]
// ---------------------------------------------------------------------------
// rru_pkg
// Shared types and codes for the register rename unit.
// ---------------------------------------------------------------------------
package rru_pkg;

    // operation codes of an input item
    localparam logic [2:0] OP_RENAME  = 3'd0;
    localparam logic [2:0] OP_RETIRE  = 3'd1;
    localparam logic [2:0] OP_FREE    = 3'd2;
    localparam logic [2:0] OP_CKPT    = 3'd3;
    localparam logic [2:0] OP_RESTORE = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFREE   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EX1,
        S_RD2,
        S_EX2,
        S_RD3,
        S_EX3,
        S_RET_EX,
        S_CKPT,
        S_REST,
        S_DONE
    } t_state;

endpackage

[rtl/core/register_rename_unit.sv]
// ---------------------------------------------------------------------------
// register_rename_unit
// One item at a time: the input stalls until the result of the last item has
//   been handed to the output register. Rename steps through its sources and
//   destination in turn on the single front-map RAM read port with registered
//   read data; checkpoint and restore copy the map one entry per cycle.
// Reset (sync, active low): all physical registers free, no locks, maps and
//   checkpoint slots empty through valid flops; RAM contents are not swept.
// ---------------------------------------------------------------------------
module register_rename_unit
    import rru_pkg::*;
#(
    parameter int ARCH_REGS = 16,
    parameter int PHYS_REGS = 40,
    parameter int SNAPSHOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_pc,
    input  logic        i_src1_present,
    input  logic [3:0]  i_src1_arch,
    input  logic        i_src2_present,
    input  logic [3:0]  i_src2_arch,
    input  logic        i_dest_present,
    input  logic [3:0]  i_dest_arch,
    input  logic [5:0]  i_phys_reg,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_src1_mapped,
    output logic [5:0]  o_src1_phys,
    output logic        o_src2_mapped,
    output logic [5:0]  o_src2_phys,
    output logic        o_dest_mapped,
    output logic [5:0]  o_dest_phys
);

    // index widths
    localparam int AW = $clog2(ARCH_REGS);
    localparam int PW = $clog2(PHYS_REGS);
    localparam int SW = (SNAPSHOTS > 1) ? $clog2(SNAPSHOTS) : 1;
    // snapshot RAM is addressed {slot, arch}
    localparam int SDEPTH = 2 ** (SW + AW);
    localparam logic [AW:0] CNT_END = (AW + 1)'(ARCH_REGS);

    // ---- field conversions --------------------------------------------------
    function automatic logic [AW-1:0] arch_idx(input logic [3:0] a);
        logic [AW+3:0] w;
        w = {{AW{1'b0}}, a};
        return w[AW-1:0];
    endfunction

    function automatic logic [PW-1:0] phys_idx(input logic [5:0] p);
        logic [PW+5:0] w;
        w = {{PW{1'b0}}, p};
        return w[PW-1:0];
    endfunction

    function automatic logic [5:0] phys_out(input logic [PW-1:0] p);
        logic [PW+5:0] w;
        w = {6'd0, p};
        return w[5:0];
    endfunction

    // ---- control state ------------------------------------------------------
    t_state                 r_state, n_state;
    logic [PHYS_REGS-1:0]   r_free, n_free;     // free pool
    logic [PHYS_REGS-1:0]   r_lock, n_lock;     // dest-locked registers
    logic [ARCH_REGS-1:0]   r_fv, n_fv;         // front map valid bits
    logic [ARCH_REGS-1:0]   r_cv, n_cv;         // commit map valid bits
    logic [SNAPSHOTS-1:0]   r_tv, n_tv;         // checkpoint slot in use
    logic                   r_out_valid, n_out_valid;

    // ---- payload state ------------------------------------------------------
    logic [15:0]            r_tpc [SNAPSHOTS];  // checkpoint branch pc
    logic [15:0]            n_tpc [SNAPSHOTS];
    logic [SNAPSHOTS-1:0]   r_hit, n_hit;       // restore pc matches
    logic [SW-1:0]          r_slot, n_slot;
    logic [AW:0]            r_cnt, n_cnt;       // map copy sweep counter
    logic                   r_lf_ok;            // registered lowest-free search
    logic [PW-1:0]          r_lf;
    logic                   lf_ok;
    logic [PW-1:0]          lf;

    // latched input item
    logic [2:0]             r_op;
    logic [15:0]            r_pc;
    logic                   r_s1_act, r_s2_act, r_d_act;
    logic [AW-1:0]          r_s1, r_s2, r_d;
    logic                   r_ret_ok, r_pr_ok;
    logic [PW-1:0]          r_pr;

    // result being built, and the output register
    logic [1:0]             r_w_status, n_w_status;
    logic                   r_w_s1m, n_w_s1m, r_w_s2m, n_w_s2m, r_w_dm, n_w_dm;
    logic [5:0]             r_w_s1p, n_w_s1p, r_w_s2p, n_w_s2p, r_w_dp, n_w_dp;
    logic [1:0]             r_o_status;
    logic                   r_o_s1m, r_o_s2m, r_o_dm;
    logic [5:0]             r_o_s1p, r_o_s2p, r_o_dp;

    // ---- RAM ports ----------------------------------------------------------
    logic                   f_we;
    logic [AW-1:0]          f_waddr, f_raddr;
    logic [PW-1:0]          f_wdata, f_rdata;
    logic                   c_we;
    logic [AW-1:0]          c_waddr, c_raddr;
    logic [PW-1:0]          c_wdata, c_rdata;
    logic                   s_we;
    logic [SW+AW-1:0]       s_waddr, s_raddr;
    logic [PW:0]            s_wdata, s_rdata;   // {valid, phys}

    logic                   in_acc;
    logic                   load_out;
    logic [AW:0]            cnt_m1;
    logic [AW-1:0]          prev;
    logic [SW-1:0]          empty_slot, hit_slot;

    // front rename map: phys index per arch register
    rru_ram #(.WIDTH(PW), .DEPTH(ARCH_REGS)) u_front (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    // commit map
    rru_ram #(.WIDTH(PW), .DEPTH(ARCH_REGS)) u_commit (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // checkpoint maps; a row is only read after a checkpoint filled it
    rru_ram #(.WIDTH(PW + 1), .DEPTH(SDEPTH)) u_snap (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign cnt_m1     = r_cnt - 1'b1;
    assign prev       = cnt_m1[AW-1:0];

    // lowest free physical register; registered so that EX stages see the
    // pool as left by the previous step
    always_comb begin
        lf_ok = 1'b0;
        lf    = '0;
        for (int p = PHYS_REGS - 1; p >= 0; p--) begin
            if (r_free[p]) begin
                lf_ok = 1'b1;
                lf    = PW'(p);
            end
        end
    end

    // first empty slot and first slot matching the restore pc
    always_comb begin
        empty_slot = '0;
        hit_slot   = '0;
        for (int s = SNAPSHOTS - 1; s >= 0; s--) begin
            if (!r_tv[s]) begin
                empty_slot = SW'(s);
            end
            if (r_hit[s]) begin
                hit_slot = SW'(s);
            end
        end
    end

    // ---- next state and datapath control ------------------------------------
    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_lock     = r_lock;
        n_fv       = r_fv;
        n_cv       = r_cv;
        n_tv       = r_tv;
        n_tpc      = r_tpc;
        n_hit      = r_hit;
        n_slot     = r_slot;
        n_cnt      = r_cnt;
        n_w_status = r_w_status;
        n_w_s1m    = r_w_s1m;
        n_w_s1p    = r_w_s1p;
        n_w_s2m    = r_w_s2m;
        n_w_s2p    = r_w_s2p;
        n_w_dm     = r_w_dm;
        n_w_dp     = r_w_dp;
        load_out   = 1'b0;
        f_we       = 1'b0;
        f_waddr    = '0;
        f_wdata    = '0;
        f_raddr    = '0;
        c_we       = 1'b0;
        c_waddr    = '0;
        c_wdata    = '0;
        c_raddr    = '0;
        s_we       = 1'b0;
        s_waddr    = '0;
        s_wdata    = '0;
        s_raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // tags are stable while idle: match the pc now
                    for (int s = 0; s < SNAPSHOTS; s++) begin
                        n_hit[s] = r_tv[s] && (r_tpc[s] == i_pc);
                    end
                    n_w_status = ST_OK;
                    n_w_s1m    = 1'b0;
                    n_w_s1p    = '0;
                    n_w_s2m    = 1'b0;
                    n_w_s2p    = '0;
                    n_w_dm     = 1'b0;
                    n_w_dp     = '0;
                    n_state    = S_DECODE;
                end
            end

            S_DECODE: begin
                unique case (r_op)
                    OP_RENAME: begin
                        f_raddr = r_s1;
                        n_state = S_EX1;
                    end
                    OP_RETIRE: begin
                        if (r_ret_ok) begin
                            c_raddr = r_d;
                            n_state = S_RET_EX;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_FREE: begin
                        if (r_pr_ok) begin
                            n_free[r_pr] = 1'b1;
                            n_lock[r_pr] = 1'b0;
                        end
                        n_state = S_DONE;
                    end
                    OP_CKPT: begin
                        if (&r_tv) begin
                            n_w_status = ST_FULL;
                            n_state    = S_DONE;
                        end else begin
                            n_slot  = empty_slot;
                            n_cnt   = '0;
                            n_state = S_CKPT;
                        end
                    end
                    OP_RESTORE: begin
                        if (r_hit == '0) begin
                            n_w_status = ST_NOTFOUND;
                            n_state    = S_DONE;
                        end else begin
                            n_slot  = hit_slot;
                            n_cnt   = '0;
                            n_state = S_REST;
                        end
                    end
                    default: begin
                        // unused op codes: empty result
                        n_state = S_DONE;
                    end
                endcase
            end

            // first source: read issued in S_DECODE
            S_EX1: begin
                if (r_s1_act) begin
                    if (r_fv[r_s1]) begin
                        n_w_s1m = 1'b1;
                        n_w_s1p = phys_out(f_rdata);
                    end else if (r_lf_ok) begin
                        f_we          = 1'b1;
                        f_waddr       = r_s1;
                        f_wdata       = r_lf;
                        n_fv[r_s1]    = 1'b1;
                        n_free[r_lf]  = 1'b0;
                        n_w_s1m       = 1'b1;
                        n_w_s1p       = phys_out(r_lf);
                    end else begin
                        n_w_status = ST_NOFREE;
                    end
                end
                n_state = S_RD2;
            end

            // read after the S_EX1 write has landed: no forwarding needed
            S_RD2: begin
                f_raddr = r_s2;
                n_state = S_EX2;
            end

            S_EX2: begin
                if (r_s2_act) begin
                    if (r_fv[r_s2]) begin
                        n_w_s2m = 1'b1;
                        n_w_s2p = phys_out(f_rdata);
                    end else if (r_lf_ok) begin
                        f_we          = 1'b1;
                        f_waddr       = r_s2;
                        f_wdata       = r_lf;
                        n_fv[r_s2]    = 1'b1;
                        n_free[r_lf]  = 1'b0;
                        n_w_s2m       = 1'b1;
                        n_w_s2p       = phys_out(r_lf);
                    end else begin
                        n_w_status = ST_NOFREE;
                    end
                end
                n_state = S_RD3;
            end

            S_RD3: begin
                f_raddr = r_d;
                n_state = S_EX3;
            end

            // destination always takes a new register; the old mapping is
            // only reported when the pool is empty
            S_EX3: begin
                if (r_d_act) begin
                    if (r_lf_ok) begin
                        f_we          = 1'b1;
                        f_waddr       = r_d;
                        f_wdata       = r_lf;
                        n_fv[r_d]     = 1'b1;
                        n_free[r_lf]  = 1'b0;
                        n_lock[r_lf]  = 1'b1;
                        n_w_dm        = 1'b1;
                        n_w_dp        = phys_out(r_lf);
                    end else begin
                        n_w_status = ST_NOFREE;
                        n_w_dm     = r_fv[r_d];
                        n_w_dp     = r_fv[r_d] ? phys_out(f_rdata) : 6'd0;
                    end
                end
                n_state = S_DONE;
            end

            // release the old commit mapping, then commit the new one
            S_RET_EX: begin
                if (r_cv[r_d] && (32'(c_rdata) < PHYS_REGS)) begin
                    n_free[c_rdata] = 1'b1;
                    n_lock[c_rdata] = 1'b0;
                end
                c_we      = 1'b1;
                c_waddr   = r_d;
                c_wdata   = r_pr;
                n_cv[r_d] = 1'b1;
                n_state   = S_DONE;
            end

            // copy front map into the slot, read k while writing k-1
            S_CKPT: begin
                if (r_cnt < CNT_END) begin
                    f_raddr = r_cnt[AW-1:0];
                end
                if (r_cnt != '0) begin
                    s_we    = 1'b1;
                    s_waddr = {r_slot, prev};
                    s_wdata = r_fv[prev] ? {1'b1, f_rdata} : '0;
                end
                if (r_cnt == CNT_END) begin
                    n_tv[r_slot]  = 1'b1;
                    n_tpc[r_slot] = r_pc;
                    n_state       = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // copy the slot back into the front map, then empty the slot
            S_REST: begin
                if (r_cnt < CNT_END) begin
                    s_raddr = {r_slot, r_cnt[AW-1:0]};
                end
                if (r_cnt != '0) begin
                    f_we       = 1'b1;
                    f_waddr    = prev;
                    f_wdata    = s_rdata[PW-1:0];
                    n_fv[prev] = s_rdata[PW];
                end
                if (r_cnt == CNT_END) begin
                    n_tv[r_slot]  = 1'b0;
                    n_tpc[r_slot] = '0;
                    n_state       = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ---- control registers --------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '1;
            r_lock      <= '0;
            r_fv        <= '0;
            r_cv        <= '0;
            r_tv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_lock      <= n_lock;
            r_fv        <= n_fv;
            r_cv        <= n_cv;
            r_tv        <= n_tv;
            r_out_valid <= n_out_valid;
        end
    end

    // ---- payload registers --------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_op;
            r_pc     <= i_pc;
            r_s1_act <= i_src1_present && (32'(i_src1_arch) < ARCH_REGS);
            r_s2_act <= i_src2_present && (32'(i_src2_arch) < ARCH_REGS);
            r_d_act  <= i_dest_present && (32'(i_dest_arch) < ARCH_REGS);
            r_s1     <= arch_idx(i_src1_arch);
            r_s2     <= arch_idx(i_src2_arch);
            r_d      <= arch_idx(i_dest_arch);
            r_ret_ok <= (32'(i_dest_arch) < ARCH_REGS) && (32'(i_phys_reg) < PHYS_REGS);
            r_pr_ok  <= (32'(i_phys_reg) < PHYS_REGS);
            r_pr     <= phys_idx(i_phys_reg);
        end
        r_tpc      <= n_tpc;
        r_hit      <= n_hit;
        r_slot     <= n_slot;
        r_cnt      <= n_cnt;
        r_lf_ok    <= lf_ok;
        r_lf       <= lf;
        r_w_status <= n_w_status;
        r_w_s1m    <= n_w_s1m;
        r_w_s1p    <= n_w_s1p;
        r_w_s2m    <= n_w_s2m;
        r_w_s2p    <= n_w_s2p;
        r_w_dm     <= n_w_dm;
        r_w_dp     <= n_w_dp;
        if (load_out) begin
            r_o_status <= r_w_status;
            r_o_s1m    <= r_w_s1m;
            r_o_s1p    <= r_w_s1p;
            r_o_s2m    <= r_w_s2m;
            r_o_s2p    <= r_w_s2p;
            r_o_dm     <= r_w_dm;
            r_o_dp     <= r_w_dp;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_src1_mapped = r_o_s1m;
    assign o_src1_phys   = r_o_s1p;
    assign o_src2_mapped = r_o_s2m;
    assign o_src2_phys   = r_o_s2p;
    assign o_dest_mapped = r_o_dm;
    assign o_dest_phys   = r_o_dp;

    // ---- assertions ---------------------------------------------------------
    // a dest-locked register is never in the free pool
    a_lock_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lock & r_free) == '0)
        else $error("locked physical register is marked free");

    // a result only appears from the hand-off state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside hand-off");

    // checkpoint copy targets an empty slot
    a_ckpt_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CKPT) |-> !r_tv[r_slot])
        else $error("checkpoint copy into a slot in use");

    // restore copy reads from a slot in use
    a_rest_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REST) |-> r_tv[r_slot])
        else $error("restore from an empty slot");

    // sweep counter stays within the map
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CKPT) || (r_state == S_REST)) |-> (r_cnt <= CNT_END))
        else $error("map copy counter out of range");

endmodule

[rtl/core/rru_ram.sv]
// ---------------------------------------------------------------------------
// rru_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[test/register_rename_unit_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// register_rename_unit_checker
// Watches both channels of the rename unit. It keeps its own copy of the
// rename maps, free pool and checkpoint slots, works out the result of each
// accepted item and compares every accepted result with the oldest one due.
// ---------------------------------------------------------------------------
module register_rename_unit_checker
    import rru_pkg::*;
#(
    parameter int ARCH_REGS = 16,
    parameter int PHYS_REGS = 40,
    parameter int SNAPSHOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_pc,
    input  logic        i_src1_present,
    input  logic [3:0]  i_src1_arch,
    input  logic        i_src2_present,
    input  logic [3:0]  i_src2_arch,
    input  logic        i_dest_present,
    input  logic [3:0]  i_dest_arch,
    input  logic [5:0]  i_phys_reg,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic        i_src1_mapped,
    input  logic [5:0]  i_src1_phys,
    input  logic        i_src2_mapped,
    input  logic [5:0]  i_src2_phys,
    input  logic        i_dest_mapped,
    input  logic [5:0]  i_dest_phys,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [1:0] status;
        logic       src1_mapped;
        logic [5:0] src1_phys;
        logic       src2_mapped;
        logic [5:0] src2_phys;
        logic       dest_mapped;
        logic [5:0] dest_phys;
    } rename_result_t;

    // shadow state
    logic       reg_free   [PHYS_REGS];
    logic       reg_locked [PHYS_REGS];
    logic       front_ok   [ARCH_REGS];
    logic [5:0] front_reg  [ARCH_REGS];
    logic       commit_ok  [ARCH_REGS];
    logic [5:0] commit_reg [ARCH_REGS];
    logic       slot_used  [SNAPSHOTS];
    logic [15:0] slot_pc   [SNAPSHOTS];
    logic       slot_ok    [SNAPSHOTS][ARCH_REGS];
    logic [5:0] slot_reg   [SNAPSHOTS][ARCH_REGS];

    rename_result_t results_due[$];
    rename_result_t seen_res;
    rename_result_t due_res;
    int fails   = 0;
    int checked = 0;

    function automatic int lowest_free_reg();
        for (int i = 0; i < PHYS_REGS; i++) begin
            if (reg_free[i]) return i;
        end
        return -1;
    endfunction

    task automatic release_reg(input int p);
        if (p < PHYS_REGS) begin
            reg_free[p]   = 1'b1;
            reg_locked[p] = 1'b0;
        end
    endtask

    task automatic clear_slot(input int s);
        slot_used[s] = 1'b0;
        slot_pc[s]   = '0;
        for (int a = 0; a < ARCH_REGS; a++) begin
            slot_ok[s][a]  = 1'b0;
            slot_reg[s][a] = '0;
        end
    endtask

    task automatic reset_shadow();
        for (int i = 0; i < PHYS_REGS; i++) begin
            reg_free[i]   = 1'b1;
            reg_locked[i] = 1'b0;
        end
        for (int a = 0; a < ARCH_REGS; a++) begin
            front_ok[a]   = 1'b0;
            front_reg[a]  = '0;
            commit_ok[a]  = 1'b0;
            commit_reg[a] = '0;
        end
        for (int s = 0; s < SNAPSHOTS; s++) clear_slot(s);
        results_due.delete();
    endtask

    // an unmapped source grabs the lowest free register
    task automatic map_source(input logic present, input logic [3:0] arch,
                              output logic mapped, output logic [5:0] phys,
                              inout logic [1:0] st);
        int f;
        mapped = 1'b0;
        phys   = '0;
        if (present && int'(arch) < ARCH_REGS) begin
            if (!front_ok[arch]) begin
                f = lowest_free_reg();
                if (f < 0) begin
                    st = ST_NOFREE;
                end else begin
                    front_ok[arch]  = 1'b1;
                    front_reg[arch] = 6'(f);
                    reg_free[f]     = 1'b0;
                end
            end
            mapped = front_ok[arch];
            phys   = front_ok[arch] ? front_reg[arch] : '0;
        end
    endtask

    task automatic predict_rename_result(output rename_result_t res);
        int f;
        int slot;
        logic [1:0] st;
        logic m1, m2;
        logic [5:0] p1, p2;
        res  = '0;
        st   = ST_OK;
        slot = -1;
        case (i_op)
            OP_RENAME: begin
                map_source(i_src1_present, i_src1_arch, m1, p1, st);
                map_source(i_src2_present, i_src2_arch, m2, p2, st);
                res.src1_mapped = m1;
                res.src1_phys   = p1;
                res.src2_mapped = m2;
                res.src2_phys   = p2;
                // destination always takes a fresh register, old map kept if dry
                if (i_dest_present && int'(i_dest_arch) < ARCH_REGS) begin
                    f = lowest_free_reg();
                    if (f < 0) begin
                        st = ST_NOFREE;
                    end else begin
                        front_ok[i_dest_arch]  = 1'b1;
                        front_reg[i_dest_arch] = 6'(f);
                        reg_free[f]            = 1'b0;
                        reg_locked[f]          = 1'b1;
                    end
                    res.dest_mapped = front_ok[i_dest_arch];
                    res.dest_phys   = front_ok[i_dest_arch] ? front_reg[i_dest_arch] : '0;
                end
            end
            OP_RETIRE: begin
                if (int'(i_dest_arch) < ARCH_REGS && int'(i_phys_reg) < PHYS_REGS) begin
                    if (commit_ok[i_dest_arch]) release_reg(int'(commit_reg[i_dest_arch]));
                    commit_ok[i_dest_arch]  = 1'b1;
                    commit_reg[i_dest_arch] = i_phys_reg;
                end
            end
            OP_FREE: begin
                release_reg(int'(i_phys_reg));
            end
            OP_CKPT: begin
                for (int s = 0; s < SNAPSHOTS; s++) begin
                    if (!slot_used[s] && slot < 0) slot = s;
                end
                if (slot < 0) begin
                    st = ST_FULL;
                end else begin
                    slot_used[slot] = 1'b1;
                    slot_pc[slot]   = i_pc;
                    for (int a = 0; a < ARCH_REGS; a++) begin
                        slot_ok[slot][a]  = front_ok[a];
                        slot_reg[slot][a] = front_reg[a];
                    end
                end
            end
            OP_RESTORE: begin
                // lowest slot wins when a pc was saved twice
                for (int s = 0; s < SNAPSHOTS; s++) begin
                    if (slot_used[s] && slot_pc[s] == i_pc && slot < 0) slot = s;
                end
                if (slot < 0) begin
                    st = ST_NOTFOUND;
                end else begin
                    for (int a = 0; a < ARCH_REGS; a++) begin
                        front_ok[a]  = slot_ok[slot][a];
                        front_reg[a] = slot_reg[slot][a];
                    end
                    clear_slot(slot);
                end
            end
            default: ;
        endcase
        res.status = st;
    endtask

    task automatic check_field(input string name, input int due, input int seen);
        if (due != seen) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, due, seen);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_shadow();
        end else begin
            // results first, so a result cannot match an item taken this edge
            if (i_out_valid && !i_out_stall) begin
                seen_res.status      = i_status;
                seen_res.src1_mapped = i_src1_mapped;
                seen_res.src1_phys   = i_src1_phys;
                seen_res.src2_mapped = i_src2_mapped;
                seen_res.src2_phys   = i_src2_phys;
                seen_res.dest_mapped = i_dest_mapped;
                seen_res.dest_phys   = i_dest_phys;
                if (results_due.size() == 0) begin
                    $display("%0t ns: result with nothing due, expected none, actual status %0d",
                             $time, i_status);
                    fails++;
                end else begin
                    due_res = results_due.pop_front();
                    check_field("status",      due_res.status,      seen_res.status);
                    check_field("src1_mapped", due_res.src1_mapped, seen_res.src1_mapped);
                    check_field("src1_phys",   due_res.src1_phys,   seen_res.src1_phys);
                    check_field("src2_mapped", due_res.src2_mapped, seen_res.src2_mapped);
                    check_field("src2_phys",   due_res.src2_phys,   seen_res.src2_phys);
                    check_field("dest_mapped", due_res.dest_mapped, seen_res.dest_mapped);
                    check_field("dest_phys",   due_res.dest_phys,   seen_res.dest_phys);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_rename_result(due_res);
                results_due.push_back(due_res);
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
        o_checked    <= checked;
    end

endmodule

[test/register_rename_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// register_rename_unit_tb
// Drives rename, retire, free, checkpoint and restore items into the rename
// unit under several idle and stall mixes; the checker beside the block
// predicts and compares every result, this module gives the verdict.
// ---------------------------------------------------------------------------
module register_rename_unit_tb;
    import rru_pkg::*;

    // one input item, field by field
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] pc;
        logic        src1_present;
        logic [3:0]  src1_arch;
        logic        src2_present;
        logic [3:0]  src2_arch;
        logic        dest_present;
        logic [3:0]  dest_arch;
        logic [5:0]  phys_reg;
    } rename_req_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [2:0]  i_op           = '0;
    logic [15:0] i_pc           = '0;
    logic        i_src1_present = 1'b0;
    logic [3:0]  i_src1_arch    = '0;
    logic        i_src2_present = 1'b0;
    logic [3:0]  i_src2_arch    = '0;
    logic        i_dest_present = 1'b0;
    logic [3:0]  i_dest_arch    = '0;
    logic [5:0]  i_phys_reg     = '0;
    logic        i_out_stall    = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic        o_src1_mapped;
    logic [5:0]  o_src1_phys;
    logic        o_src2_mapped;
    logic [5:0]  o_src2_phys;
    logic        o_dest_mapped;
    logic [5:0]  o_dest_phys;

    int fail_count;
    int results_pending;
    int results_checked;

    // idle and stall odds in percent, changed per phase
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int items_sent      = 0;

    // pcs saved by checkpoints, so most restores hit a live slot
    logic [15:0] saved_pcs[$];

    always #2 i_clk = ~i_clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    register_rename_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_pc           (i_pc),
        .i_src1_present (i_src1_present),
        .i_src1_arch    (i_src1_arch),
        .i_src2_present (i_src2_present),
        .i_src2_arch    (i_src2_arch),
        .i_dest_present (i_dest_present),
        .i_dest_arch    (i_dest_arch),
        .i_phys_reg     (i_phys_reg),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_src1_mapped  (o_src1_mapped),
        .o_src1_phys    (o_src1_phys),
        .o_src2_mapped  (o_src2_mapped),
        .o_src2_phys    (o_src2_phys),
        .o_dest_mapped  (o_dest_mapped),
        .o_dest_phys    (o_dest_phys)
    );

    register_rename_unit_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_pc           (i_pc),
        .i_src1_present (i_src1_present),
        .i_src1_arch    (i_src1_arch),
        .i_src2_present (i_src2_present),
        .i_src2_arch    (i_src2_arch),
        .i_dest_present (i_dest_present),
        .i_dest_arch    (i_dest_arch),
        .i_phys_reg     (i_phys_reg),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_src1_mapped  (o_src1_mapped),
        .i_src1_phys    (o_src1_phys),
        .i_src2_mapped  (o_src2_mapped),
        .i_src2_phys    (o_src2_phys),
        .i_dest_mapped  (o_dest_mapped),
        .i_dest_phys    (o_dest_phys),
        .o_fail_count   (fail_count),
        .o_pending      (results_pending),
        .o_checked      (results_checked)
    );

    // random base so unused fields still toggle every bit
    function automatic rename_req_t noise_req();
        return rename_req_t'(40'({$urandom, $urandom}));
    endfunction

    function automatic rename_req_t rename_req(logic s1p, logic [3:0] s1a, logic s2p,
                                               logic [3:0] s2a, logic dp, logic [3:0] da);
        rename_req_t r;
        r              = noise_req();
        r.op           = OP_RENAME;
        r.src1_present = s1p;
        r.src1_arch    = s1a;
        r.src2_present = s2p;
        r.src2_arch    = s2a;
        r.dest_present = dp;
        r.dest_arch    = da;
        return r;
    endfunction

    function automatic rename_req_t control_req(logic [2:0] op, logic [15:0] pc,
                                                logic [3:0] da, logic [5:0] pr);
        rename_req_t r;
        r           = noise_req();
        r.op        = op;
        r.pc        = pc;
        r.dest_arch = da;
        r.phys_reg  = pr;
        return r;
    endfunction

    // mostly real registers, now and then an index past the pool
    function automatic logic [5:0] pick_phys();
        if ($urandom_range(9) == 0) return 6'($urandom_range(63, 40));
        return 6'($urandom_range(39));
    endfunction

    task automatic random_req(output rename_req_t r);
        int roll;
        int idx;
        r    = noise_req();
        roll = $urandom_range(99);
        if (roll < 40) begin
            r.op           = OP_RENAME;
            r.src1_present = ($urandom_range(3) != 0);
            r.src2_present = ($urandom_range(3) != 0);
            r.dest_present = ($urandom_range(3) != 0);
        end else if (roll < 52) begin
            r.op       = OP_RETIRE;
            r.phys_reg = pick_phys();
        end else if (roll < 70) begin
            r.op       = OP_FREE;
            r.phys_reg = pick_phys();
        end else if (roll < 84) begin
            // a few small pcs repeat so duplicate slots show up
            r.op = OP_CKPT;
            if ($urandom_range(1) == 0) r.pc = 16'($urandom_range(7));
            saved_pcs.push_back(r.pc);
        end else if (roll < 95) begin
            r.op = OP_RESTORE;
            if (saved_pcs.size() > 0 && $urandom_range(4) != 0) begin
                idx  = $urandom_range(saved_pcs.size() - 1);
                r.pc = saved_pcs[idx];
                saved_pcs.delete(idx);
            end else if ($urandom_range(1) == 0) begin
                r.pc = 16'($urandom_range(7));
            end
        end else begin
            r.op = 3'($urandom_range(7, 5));
        end
    endtask

    // present one item and hold it until the block takes it
    task automatic drive_req(input rename_req_t r);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= r.op;
        i_pc           <= r.pc;
        i_src1_present <= r.src1_present;
        i_src1_arch    <= r.src1_arch;
        i_src2_present <= r.src2_present;
        i_src2_arch    <= r.src2_arch;
        i_dest_present <= r.dest_present;
        i_dest_arch    <= r.dest_arch;
        i_phys_reg     <= r.phys_reg;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    initial begin : stimulus
        rename_req_t r;
        int phase;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // save the empty map, then drain the whole pool
        drive_req(control_req(OP_CKPT, 16'hFFFF, 4'd0, 6'd0));
        for (int k = 0; k < 8; k++) begin
            drive_req(rename_req(1'b1, 4'(2 * k), 1'b1, 4'(2 * k + 1), 1'b1, 4'(2 * k)));
        end
        // dest-only renames, sources absent with junk arch fields
        for (int k = 0; k < 16; k++) begin
            drive_req(rename_req(1'b0, 4'($urandom), 1'b0, 4'($urandom), 1'b1, 4'(k)));
        end
        // pool dry: dest keeps and reports its old mapping
        drive_req(rename_req(1'b1, 4'd0, 1'b1, 4'd1, 1'b1, 4'd3));
        // back to the empty map while still dry: every operand fails
        drive_req(control_req(OP_RESTORE, 16'hFFFF, 4'd0, 6'd0));
        drive_req(rename_req(1'b1, 4'd5, 1'b1, 4'd5, 1'b1, 4'd7));
        // retire twice onto the same register frees it; out-of-range index ignored
        drive_req(control_req(OP_RETIRE, 16'd0, 4'd3, 6'd10));
        drive_req(control_req(OP_RETIRE, 16'd0, 4'd3, 6'd10));
        drive_req(control_req(OP_RETIRE, 16'd0, 4'd3, 6'd63));
        drive_req(control_req(OP_RETIRE, 16'd0, 4'd15, 6'd39));
        drive_req(control_req(OP_FREE, 16'd0, 4'd0, 6'd40));
        drive_req(control_req(OP_FREE, 16'd0, 4'd0, 6'd63));
        drive_req(control_req(OP_FREE, 16'd0, 4'd0, 6'd0));
        drive_req(rename_req(1'b1, 4'd4, 1'b0, 4'd0, 1'b1, 4'd2));
        drive_req(control_req(OP_RESTORE, 16'h1234, 4'd0, 6'd0));
        // unused op codes
        for (int op = 5; op < 8; op++) begin
            drive_req(control_req(3'(op), 16'($urandom), 4'($urandom), 6'($urandom)));
        end
        // same pc saved twice: restore takes the lower slot
        drive_req(control_req(OP_CKPT, 16'd0, 4'd0, 6'd0));
        drive_req(control_req(OP_CKPT, 16'd0, 4'd0, 6'd0));
        drive_req(control_req(OP_RESTORE, 16'd0, 4'd0, 6'd0));
        drive_req(rename_req(1'b0, 4'd15, 1'b0, 4'd15, 1'b0, 4'd15));
        drive_req(control_req(OP_CKPT, 16'hFFFF, 4'd0, 6'd0));
        saved_pcs.push_back(16'd0);
        saved_pcs.push_back(16'hFFFF);

        // --- random part: free run, sender gaps, receiver stalls, both ---
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1: begin
                    sender_idle_pct = 57;
                    stall_pct       = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    stall_pct       = 57;
                end
                default: begin
                    sender_idle_pct = 11;
                    stall_pct       = 11;
                end
            endcase
            repeat (150) begin
                random_req(r);
                drive_req(r);
            end
        end

        // drain: one edge so the last item is counted, then wait for results
        i_in_valid <= 1'b0;
        stall_pct = 0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        // the slowest item is a map copy
        repeat (40) @(posedge i_clk);

        $display("Covered pool exhaustion, retire and free corner cases, checkpoint reuse");
        $display("and random traffic in four idle/stall mixes: %0d items, %0d results, %0d errors",
                 items_sent, results_checked, fail_count);
        if (fail_count == 0) begin
            $display("PASS register_rename_unit");
        end else begin
            $display("FAIL register_rename_unit");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("FAIL register_rename_unit");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rru_pkg.sv
rtl/core/rru_ram.sv
rtl/core/register_rename_unit.sv
test/register_rename_unit_checker.sv
test/register_rename_unit_tb.sv
